>>> design/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is low.
`define PCV_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is low.
`define PCV_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/pcv_pkg.sv
package pcv_pkg;

    localparam int SAMPLE_W      = 24;
    localparam int CV_W          = 32;
    localparam int CNT_W         = 11;
    localparam int SUM_W         = 34;
    localparam int SQ_W          = 58;
    localparam int TOT_W         = 50;
    localparam int PCNT_W        = 17;
    localparam int MAX_GROUP_LEN = 1024;

    // shared adder and the working registers around it
    localparam int ALU_W    = 78;
    localparam int MPL_W    = 34;
    localparam int ITER_W   = 7;
    localparam int Q_W      = 64;
    localparam int ROOT_W   = 32;
    localparam int DSHIFT   = 30;
    localparam int DIV_STEPS     = 64;
    localparam int SQRT_STEPS    = 32;
    localparam int ROW_DIV_STEPS = 50;

    localparam logic [CV_W-1:0]   CV_MAX   = {1'b0, {(CV_W-1){1'b1}}};
    localparam logic [CV_W-1:0]   CV_MIN   = {1'b1, {(CV_W-1){1'b0}}};
    localparam logic [TOT_W-1:0]  TOT_MAX  = {1'b0, {(TOT_W-1){1'b1}}};
    localparam logic [TOT_W-1:0]  TOT_MIN  = {1'b1, {(TOT_W-1){1'b0}}};
    localparam logic [PCNT_W-1:0] PCNT_MAX = {PCNT_W{1'b1}};

    typedef enum logic [14:0] {
        ST_IDLE  = 15'b000000000000001,
        ST_CLOSE = 15'b000000000000010,
        ST_MUL   = 15'b000000000000100,
        ST_SUBD  = 15'b000000000001000,
        ST_DCHK  = 15'b000000000010000,
        ST_DIV   = 15'b000000000100000,
        ST_SQRT  = 15'b000000001000000,
        ST_KCALC = 15'b000000010000000,
        ST_TOT   = 15'b000000100000000,
        ST_FIN   = 15'b000001000000000,
        ST_ROW   = 15'b000010000000000,
        ST_RND   = 15'b000100000000000,
        ST_RDIV  = 15'b001000000000000,
        ST_RFIN  = 15'b010000000000000,
        ST_ROUT  = 15'b100000000000000
    } state_t;

    typedef enum logic [2:0] {
        PH_S2 = 3'd0,
        PH_NQ = 3'd1,
        PH_ND = 3'd2,
        PH_B  = 3'd3,
        PH_K  = 3'd4
    } mul_ph_t;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } alu_req_t;

    typedef struct packed {
        logic [ALU_W-1:0] sum;
        logic             carry;
    } alu_rsp_t;

endpackage

>>> design/pcv_alu.sv
module pcv_alu (
    input  pcv_pkg::alu_req_t req,
    output pcv_pkg::alu_rsp_t rsp
);
    import pcv_pkg::*;

    logic [ALU_W:0] total;

    // carry out of a subtract means a >= b
    assign total = {1'b0, req.a} + {1'b0, (req.sub ? ~req.b : req.b)}
                 + {{ALU_W{1'b0}}, req.sub};
    assign rsp.sum   = total[ALU_W-1:0];
    assign rsp.carry = total[ALU_W];

endmodule

>>> design/pooled_coefficient_of_variation.sv
// Channel  Direction  Ports                                              Request
// s_       in         s_sample_value s_is_missing s_group_last s_row_last  one matrix sample
// m_       out        m_pooled_cv m_row_empty m_mean_zero                  one row result
//
// A group close holds s_ready low; with two or more values and a non-zero sum it runs
// shift-add multiplies, bit-serial divide and square root, which share one 78-bit adder.
// A row end also holds it low for the row result, with a rounding step and a row divide
// unless the row is empty or zero-mean. Reset clears the accumulators and the output slot.
// A stalled result holds in the output register while later samples are taken; a row
// end waits only while that slot is still full.
module pooled_coefficient_of_variation (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [pcv_pkg::SAMPLE_W-1:0] s_sample_value,
    input  logic                                s_is_missing,
    input  logic                                s_group_last,
    input  logic                                s_row_last,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [pcv_pkg::CV_W-1:0]     m_pooled_cv,
    output logic                                m_row_empty,
    output logic                                m_mean_zero
);
    import pcv_pkg::*;

    state_t  state_reg, state_next;
    mul_ph_t ph_reg, ph_next;
    logic    row_end_reg, row_end_next;

    // group and row accumulators
    logic [CNT_W-1:0]        gcnt_reg, gcnt_next;
    logic signed [SUM_W-1:0] gsum_reg, gsum_next;
    logic [SQ_W-1:0]         gsq_reg, gsq_next;
    logic signed [TOT_W-1:0] tot_reg, tot_next;
    logic [PCNT_W-1:0]       pcnt_reg, pcnt_next;
    logic                    zero_reg, zero_next;

    // working registers of the shared unit
    logic [ALU_W-1:0]  acc_reg, acc_next;
    logic [ALU_W-1:0]  mcand_reg, mcand_next;
    logic [MPL_W-1:0]  mplier_reg, mplier_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic [ALU_W-1:0]  s2_reg, s2_next;
    logic [ALU_W-1:0]  nd_reg, nd_next;
    logic [ALU_W-1:0]  bdiv_reg, bdiv_next;
    logic [ALU_W-1:0]  rem_reg, rem_next;
    logic [Q_W-1:0]    quo_reg, quo_next;
    logic [Q_W-1:0]    dsr_reg, dsr_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [CV_W-1:0]   k_reg, k_next;
    logic [CV_W-1:0]   res_reg, res_next;
    logic              empty_reg, empty_next;
    logic              mz_reg, mz_next;

    // output slot
    logic            m_valid_reg, m_valid_next;
    logic [CV_W-1:0] m_cv_reg, m_cv_next;
    logic            m_empty_reg, m_empty_next;
    logic            m_mz_reg, m_mz_next;

    alu_req_t alu_req;
    alu_rsp_t alu_rsp;

    logic                        s_acc;
    logic signed [2*SAMPLE_W-1:0] vsq;
    logic [ALU_W-1:0]            mul_sum;
    logic [ALU_W-1:0]            nd_top;
    logic [ALU_W-1:0]            tot_ext;
    logic [PCNT_W:0]             pcnt_sum;
    logic [ALU_W-TOT_W:0]        tot_hi;

    assign s_ready     = (state_reg == ST_IDLE);
    assign s_acc       = s_valid && s_ready;
    assign m_valid     = m_valid_reg;
    assign m_pooled_cv = m_cv_reg;
    assign m_row_empty = m_empty_reg;
    assign m_mean_zero = m_mz_reg;

    assign vsq      = s_sample_value * s_sample_value;
    assign nd_top   = nd_reg >> DSHIFT;
    assign tot_ext  = ALU_W'(tot_reg);
    assign mul_sum  = mplier_reg[0] ? alu_rsp.sum : acc_reg;
    assign pcnt_sum = {1'b0, pcnt_reg} + (PCNT_W+1)'(gcnt_reg);
    assign tot_hi   = alu_rsp.sum[ALU_W-1:TOT_W-1];

    pcv_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // operand selection for the shared adder
    always_comb begin
        alu_req = '0;
        unique case (state_reg)
            ST_CLOSE: begin
                alu_req.b   = ALU_W'(gsum_reg);
                alu_req.sub = 1'b1;
            end
            ST_MUL: begin
                alu_req.a = acc_reg;
                alu_req.b = mcand_reg;
            end
            ST_SUBD: begin
                alu_req.a   = acc_reg;
                alu_req.b   = s2_reg;
                alu_req.sub = 1'b1;
            end
            ST_DCHK: begin
                alu_req.a   = nd_top;
                alu_req.b   = bdiv_reg;
                alu_req.sub = 1'b1;
            end
            ST_DIV: begin
                alu_req.a   = {rem_reg[ALU_W-2:0], dsr_reg[Q_W-1]};
                alu_req.b   = bdiv_reg;
                alu_req.sub = 1'b1;
            end
            ST_SQRT: begin
                alu_req.a   = {rem_reg[ALU_W-3:0], quo_reg[Q_W-1:Q_W-2]};
                alu_req.b   = ALU_W'({root_reg, 2'b01});
                alu_req.sub = 1'b1;
            end
            ST_KCALC: begin
                alu_req.a = ALU_W'(root_reg);
                alu_req.b = ALU_W'(1);
            end
            ST_TOT: begin
                alu_req.a   = tot_ext;
                alu_req.b   = acc_reg;
                alu_req.sub = gsum_reg[SUM_W-1];
            end
            ST_ROW: begin
                alu_req.b   = tot_ext;
                alu_req.sub = 1'b1;
            end
            ST_RND: begin
                alu_req.a = acc_reg;
                alu_req.b = ALU_W'(pcnt_reg >> 1);
            end
            ST_RDIV: begin
                alu_req.a   = {rem_reg[ALU_W-2:0], dsr_reg[Q_W-1]};
                alu_req.b   = ALU_W'(pcnt_reg);
                alu_req.sub = 1'b1;
            end
            ST_RFIN: begin
                alu_req.b   = ALU_W'(quo_reg);
                alu_req.sub = 1'b1;
            end
            default: alu_req = '0;
        endcase
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        ph_next      = ph_reg;
        row_end_next = row_end_reg;
        gcnt_next    = gcnt_reg;
        gsum_next    = gsum_reg;
        gsq_next     = gsq_reg;
        tot_next     = tot_reg;
        pcnt_next    = pcnt_reg;
        zero_next    = zero_reg;
        acc_next     = acc_reg;
        mcand_next   = mcand_reg;
        mplier_next  = mplier_reg;
        iter_next    = iter_reg;
        s2_next      = s2_reg;
        nd_next      = nd_reg;
        bdiv_next    = bdiv_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        dsr_next     = dsr_reg;
        root_next    = root_reg;
        k_next       = k_reg;
        res_next     = res_reg;
        empty_next   = empty_reg;
        mz_next      = mz_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_cv_next    = m_cv_reg;
        m_empty_next = m_empty_reg;
        m_mz_next    = m_mz_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    // drop missing samples and anything past the group length cap
                    if (!s_is_missing && gcnt_reg < CNT_W'(MAX_GROUP_LEN)) begin
                        gcnt_next = gcnt_reg + CNT_W'(1);
                        gsum_next = gsum_reg + SUM_W'(s_sample_value);
                        gsq_next  = gsq_reg + SQ_W'(unsigned'(vsq));
                    end
                    if (s_group_last || s_row_last) begin
                        row_end_next = s_row_last;
                        state_next   = ST_CLOSE;
                    end
                end
            end
            ST_CLOSE: begin
                if (gcnt_reg < CNT_W'(2)) begin
                    state_next = ST_FIN;
                end else if (gsum_reg == '0) begin
                    zero_next  = 1'b1;
                    state_next = ST_FIN;
                end else begin
                    // start |S| * |S|
                    mcand_next  = gsum_reg[SUM_W-1] ? alu_rsp.sum : ALU_W'(gsum_reg);
                    mplier_next = gsum_reg[SUM_W-1] ? alu_rsp.sum[MPL_W-1:0]
                                                    : MPL_W'(gsum_reg);
                    acc_next    = '0;
                    iter_next   = ITER_W'(MPL_W);
                    ph_next     = PH_S2;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL: begin
                acc_next    = mul_sum;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                iter_next   = iter_reg - ITER_W'(1);
                if (iter_reg == ITER_W'(1)) begin
                    case (ph_reg)
                        PH_S2: begin
                            s2_next     = mul_sum;
                            acc_next    = '0;
                            mcand_next  = ALU_W'(gsq_reg);
                            mplier_next = MPL_W'(gcnt_reg);
                            iter_next   = ITER_W'(CNT_W);
                            ph_next     = PH_NQ;
                        end
                        PH_NQ: state_next = ST_SUBD;
                        PH_ND: begin
                            nd_next     = mul_sum;
                            acc_next    = '0;
                            mcand_next  = s2_reg;
                            mplier_next = MPL_W'(gcnt_reg - CNT_W'(1));
                            iter_next   = ITER_W'(CNT_W);
                            ph_next     = PH_B;
                        end
                        PH_B: begin
                            bdiv_next  = mul_sum;
                            state_next = ST_DCHK;
                        end
                        default: state_next = ST_TOT;
                    endcase
                end
            end
            ST_SUBD: begin
                // D = n*Q - S*S, floored at zero
                mcand_next  = alu_rsp.carry ? alu_rsp.sum : '0;
                mplier_next = MPL_W'(gcnt_reg);
                acc_next    = '0;
                iter_next   = ITER_W'(CNT_W);
                ph_next     = PH_ND;
                state_next  = ST_MUL;
            end
            ST_DCHK: begin
                if (alu_rsp.carry) begin
                    // quotient would pass 64 bits: cv saturates
                    k_next      = CV_MAX;
                    mcand_next  = ALU_W'(CV_MAX);
                    mplier_next = MPL_W'(gcnt_reg);
                    acc_next    = '0;
                    iter_next   = ITER_W'(CNT_W);
                    ph_next     = PH_K;
                    state_next  = ST_MUL;
                end else begin
                    rem_next   = nd_top;
                    dsr_next   = {nd_reg[DSHIFT-1:0], {(Q_W-DSHIFT){1'b0}}};
                    quo_next   = '0;
                    iter_next  = ITER_W'(DIV_STEPS);
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                quo_next  = {quo_reg[Q_W-2:0], alu_rsp.carry};
                rem_next  = alu_rsp.carry ? alu_rsp.sum : alu_req.a;
                dsr_next  = dsr_reg << 1;
                iter_next = iter_reg - ITER_W'(1);
                if (iter_reg == ITER_W'(1)) begin
                    rem_next   = '0;
                    root_next  = '0;
                    iter_next  = ITER_W'(SQRT_STEPS);
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (alu_rsp.carry) begin
                    rem_next  = alu_rsp.sum;
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end else begin
                    rem_next  = alu_req.a;
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                quo_next  = quo_reg << 2;
                iter_next = iter_reg - ITER_W'(1);
                if (iter_reg == ITER_W'(1)) begin
                    state_next = ST_KCALC;
                end
            end
            ST_KCALC: begin
                // k = (isqrt + 1) / 2, clamp at the Q16.16 ceiling
                k_next      = alu_rsp.sum[CV_W] ? CV_MAX : alu_rsp.sum[CV_W:1];
                mcand_next  = alu_rsp.sum[CV_W] ? ALU_W'(CV_MAX)
                                                : ALU_W'(alu_rsp.sum[CV_W:1]);
                mplier_next = MPL_W'(gcnt_reg);
                acc_next    = '0;
                iter_next   = ITER_W'(CNT_W);
                ph_next     = PH_K;
                state_next  = ST_MUL;
            end
            ST_TOT: begin
                if ((&tot_hi) || !(|tot_hi)) begin
                    tot_next = signed'(alu_rsp.sum[TOT_W-1:0]);
                end else begin
                    tot_next = signed'(alu_rsp.sum[ALU_W-1] ? TOT_MIN : TOT_MAX);
                end
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (gcnt_reg >= CNT_W'(2)) begin
                    pcnt_next = pcnt_sum[PCNT_W] ? PCNT_MAX : pcnt_sum[PCNT_W-1:0];
                end
                gcnt_next  = '0;
                gsum_next  = '0;
                gsq_next   = '0;
                state_next = row_end_reg ? ST_ROW : ST_IDLE;
            end
            ST_ROW: begin
                empty_next = 1'b0;
                mz_next    = 1'b0;
                if (pcnt_reg == '0) begin
                    res_next   = '0;
                    empty_next = 1'b1;
                    state_next = ST_ROUT;
                end else if (zero_reg) begin
                    res_next   = CV_MAX;
                    mz_next    = 1'b1;
                    state_next = ST_ROUT;
                end else begin
                    acc_next   = tot_reg[TOT_W-1] ? alu_rsp.sum : ALU_W'(unsigned'(tot_reg));
                    state_next = ST_RND;
                end
            end
            ST_RND: begin
                dsr_next   = {alu_rsp.sum[TOT_W-1:0], {(Q_W-TOT_W){1'b0}}};
                rem_next   = '0;
                quo_next   = '0;
                iter_next  = ITER_W'(ROW_DIV_STEPS);
                state_next = ST_RDIV;
            end
            ST_RDIV: begin
                quo_next  = {quo_reg[Q_W-2:0], alu_rsp.carry};
                rem_next  = alu_rsp.carry ? alu_rsp.sum : alu_req.a;
                dsr_next  = dsr_reg << 1;
                iter_next = iter_reg - ITER_W'(1);
                if (iter_reg == ITER_W'(1)) begin
                    state_next = ST_RFIN;
                end
            end
            ST_RFIN: begin
                if (tot_reg[TOT_W-1]) begin
                    if ((|quo_reg[TOT_W-1:CV_W])
                        || (quo_reg[CV_W-1] && (|quo_reg[CV_W-2:0]))) begin
                        res_next = CV_MIN;
                    end else begin
                        res_next = alu_rsp.sum[CV_W-1:0];
                    end
                end else begin
                    res_next = (|quo_reg[TOT_W-1:CV_W-1]) ? CV_MAX : quo_reg[CV_W-1:0];
                end
                state_next = ST_ROUT;
            end
            ST_ROUT: begin
                // hold until the output slot is free, then clear the row
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_cv_next    = res_reg;
                    m_empty_next = empty_reg;
                    m_mz_next    = mz_reg;
                    tot_next     = '0;
                    pcnt_next    = '0;
                    zero_next    = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ph_reg      <= PH_S2;
            row_end_reg <= 1'b0;
            gcnt_reg    <= '0;
            gsum_reg    <= '0;
            gsq_reg     <= '0;
            tot_reg     <= '0;
            pcnt_reg    <= '0;
            zero_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ph_reg      <= ph_next;
            row_end_reg <= row_end_next;
            gcnt_reg    <= gcnt_next;
            gsum_reg    <= gsum_next;
            gsq_reg     <= gsq_next;
            tot_reg     <= tot_next;
            pcnt_reg    <= pcnt_next;
            zero_reg    <= zero_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg     <= acc_next;
        mcand_reg   <= mcand_next;
        mplier_reg  <= mplier_next;
        iter_reg    <= iter_next;
        s2_reg      <= s2_next;
        nd_reg      <= nd_next;
        bdiv_reg    <= bdiv_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        dsr_reg     <= dsr_next;
        root_reg    <= root_next;
        k_reg       <= k_next;
        res_reg     <= res_next;
        empty_reg   <= empty_next;
        mz_reg      <= mz_next;
        m_cv_reg    <= m_cv_next;
        m_empty_reg <= m_empty_next;
        m_mz_reg    <= m_mz_next;
    end

endmodule

>>> design/pcv_checker.sv
`include "assert_macros.svh"

module pcv_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            s_row_last,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic signed [pcv_pkg::CV_W-1:0] m_pooled_cv,
    input logic                            m_row_empty,
    input logic                            m_mean_zero
);
    import pcv_pkg::*;

    // an empty row carries a zero result and no zero-mean flag
    `PCV_ASSERT_SAME(a_empty_zero, aclk, aresetn, m_valid && m_row_empty, m_pooled_cv == '0 && !m_mean_zero, "empty row with non-zero result")
    // a zero-mean row is saturated and not empty
    `PCV_ASSERT_SAME(a_mz_sat, aclk, aresetn, m_valid && m_mean_zero, m_pooled_cv == CV_MAX && !m_row_empty, "zero-mean row not saturated")
    // a row end always busies the block in the cycle after it is taken
    `PCV_ASSERT_NEXT(a_row_busy, aclk, aresetn, s_valid && s_ready && s_row_last, !s_ready, "request taken straight after a row end")
    // a stalled result holds
    `PCV_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_pooled_cv), "stalled result changed")

endmodule

bind pooled_coefficient_of_variation pcv_checker u_pcv_checker (.*);
